@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked assertions with reset disable; compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/emaf_pkg.sv @@
// ---------------------------------------------------------------------------
// emaf_pkg
// shared widths, register indexes and types of the exponential filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package emaf_pkg;

    // geometry
    localparam int CHANNELS    = 64;
    localparam int CH_BITS     = 6;
    localparam int SLOT_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS;
    localparam int VALUE_BITS  = AVG_BITS + 1;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS   = AVG_BITS + WEIGHT_BITS + 1;
    localparam int WPROD_BITS  = SAMPLE_BITS + WEIGHT_BITS + 1;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q   = WEIGHT_BITS'(1) << FRAC_BITS;
    localparam logic [PROD_BITS-1:0]   ROUND_Q = PROD_BITS'(1) << (FRAC_BITS - 1);

    // stream words, packed to whole bytes
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + CH_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_DATA_BITS = ((VALUE_BITS + CH_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = WEIGHT_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWPASS_MODE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEW_WEIGHT   = 1'd1;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // settled configuration seen by the datapath
    typedef struct packed {
        logic                   lowpass;
        logic [WEIGHT_BITS-1:0] weight;       // saturated to one
        logic [WEIGHT_BITS-1:0] keep_weight;  // one minus weight
    } emaf_cfg_t;

    // one classified sample on its way to the update unit
    typedef struct packed {
        logic                   init;
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_BITS-1:0]     channel;
        logic [AVG_BITS-1:0]    new_part;     // sample times weight, 16 fraction bits
    } emaf_cmd_t;

    // queue status
    typedef struct packed {
        logic full;
        logic valid;
    } emaf_qstat_t;

endpackage

@@ hw/rtl/emaf_queue.sv @@
// ---------------------------------------------------------------------------
// emaf_queue
// short command fifo between the front and the update unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emaf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  emaf_pkg::emaf_cmd_t push_cmd,
    input  logic                pop,
    output emaf_pkg::emaf_cmd_t head_cmd,
    output emaf_pkg::emaf_qstat_t stat
);

    emaf_pkg::emaf_cmd_t                 entry_reg [emaf_pkg::QUEUE_DEPTH];
    logic [emaf_pkg::QPTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [emaf_pkg::QPTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [emaf_pkg::QCNT_BITS-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == emaf_pkg::QPTR_BITS'(emaf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == emaf_pkg::QPTR_BITS'(emaf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == emaf_pkg::QCNT_BITS'(emaf_pkg::QUEUE_DEPTH));

endmodule

@@ hw/rtl/emaf_front.sv @@
// ---------------------------------------------------------------------------
// emaf_front
// input stage: takes samples, forms the weighted new part, feeds the queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emaf_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [emaf_pkg::SAMPLE_BITS-1:0]    in_sample,
    input  logic [emaf_pkg::CH_BITS-1:0]        in_channel,
    input  logic                                in_init,
    input  emaf_pkg::emaf_cfg_t                 cfg,
    input  emaf_pkg::emaf_qstat_t               qstat,
    output logic                                push,
    output emaf_pkg::emaf_cmd_t                 push_cmd
);

    logic                                       valid_reg, valid_next;
    emaf_pkg::emaf_cmd_t                        cmd_reg;
    logic                                       accept;
    logic signed [emaf_pkg::SAMPLE_BITS-1:0]    sample_s;
    logic signed [emaf_pkg::WEIGHT_BITS:0]      weight_s;
    logic signed [emaf_pkg::WPROD_BITS-1:0]     wprod;

    assign push     = valid_reg && !qstat.full;
    assign in_ready = !valid_reg || push;
    assign accept   = in_valid && in_ready;

    // sample * w carries 16 fraction bits and always fits the average width
    assign sample_s = $signed(in_sample);
    assign weight_s = $signed({1'b0, cfg.weight});
    assign wprod    = sample_s * weight_s;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.init     <= in_init;
            cmd_reg.sample   <= in_sample;
            cmd_reg.channel  <= in_channel;
            cmd_reg.new_part <= wprod[emaf_pkg::AVG_BITS-1:0];
        end
    end

    assign push_cmd = cmd_reg;

endmodule

@@ hw/rtl/emaf_back.sv @@
// ---------------------------------------------------------------------------
// emaf_back
// update unit: average memory, read stage with forwarding, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emaf_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  emaf_pkg::emaf_qstat_t               qstat,
    input  emaf_pkg::emaf_cmd_t                 head_cmd,
    output logic                                pop,
    input  emaf_pkg::emaf_cfg_t                 cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [emaf_pkg::VALUE_BITS-1:0]     out_value,
    output logic [emaf_pkg::CH_BITS-1:0]        out_channel
);

    // per-channel averages, no reset
    logic [emaf_pkg::AVG_BITS-1:0]              avg_mem [emaf_pkg::CHANNELS];

    // read stage
    logic                                       s1_valid_reg, s1_valid_next;
    emaf_pkg::emaf_cmd_t                        s1_cmd_reg;
    logic [emaf_pkg::AVG_BITS-1:0]              rd_data_reg;
    logic                                       fwd_reg, fwd_next;
    logic [emaf_pkg::AVG_BITS-1:0]              last_avg_reg;

    // result register
    logic                                       out_valid_reg, out_valid_next;
    logic [emaf_pkg::VALUE_BITS-1:0]            out_value_reg;
    logic [emaf_pkg::CH_BITS-1:0]               out_channel_reg;

    logic                                       s2_free;
    logic                                       s1_fire;
    logic                                       s1_load;
    logic [emaf_pkg::SLOT_BITS-1:0]             rd_slot;
    logic [emaf_pkg::SLOT_BITS-1:0]             s1_slot;
    logic [emaf_pkg::AVG_BITS-1:0]              avg_in;
    logic signed [emaf_pkg::AVG_BITS-1:0]       avg_in_s;
    logic signed [emaf_pkg::WEIGHT_BITS:0]      keep_s;
    logic signed [emaf_pkg::PROD_BITS-1:0]      keep_prod;
    logic [emaf_pkg::PROD_BITS-1:0]             rounded;
    logic [emaf_pkg::AVG_BITS-1:0]              sample_q;
    logic [emaf_pkg::AVG_BITS-1:0]              avg_new;
    logic [emaf_pkg::VALUE_BITS-1:0]            value_new;

    assign s2_free = !out_valid_reg || out_ready;
    assign s1_fire = s1_valid_reg && s2_free;
    assign s1_load = qstat.valid && (!s1_valid_reg || s1_fire);
    assign pop     = s1_load;

    assign rd_slot = emaf_pkg::SLOT_BITS'(head_cmd.channel % emaf_pkg::CHANNELS);
    assign s1_slot = emaf_pkg::SLOT_BITS'(s1_cmd_reg.channel % emaf_pkg::CHANNELS);

    // the read taken at load misses a write to the same slot at that edge
    assign fwd_next = s1_load ? (s1_fire && (s1_slot == rd_slot)) : fwd_reg;
    assign avg_in   = fwd_reg ? last_avg_reg : rd_data_reg;

    // avg' = s*w + floor((avg*(1-w) + half) / 2^16)
    assign avg_in_s  = $signed(avg_in);
    assign keep_s    = $signed({1'b0, cfg.keep_weight});
    assign keep_prod = avg_in_s * keep_s;
    assign rounded   = keep_prod + emaf_pkg::ROUND_Q;
    assign sample_q  = {s1_cmd_reg.sample, {emaf_pkg::FRAC_BITS{1'b0}}};
    assign avg_new   = s1_cmd_reg.init
                       ? sample_q
                       : s1_cmd_reg.new_part
                         + rounded[emaf_pkg::FRAC_BITS +: emaf_pkg::AVG_BITS];

    assign value_new = cfg.lowpass
                       ? {avg_new[emaf_pkg::AVG_BITS-1], avg_new}
                       : {sample_q[emaf_pkg::AVG_BITS-1], sample_q}
                         - {avg_new[emaf_pkg::AVG_BITS-1], avg_new};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memory: write on retire, registered read on load
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            avg_mem[s1_slot] <= avg_new;
        end
        if (s1_load)
        begin
            rd_data_reg <= avg_mem[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cmd_reg <= head_cmd;
        end
        if (s1_fire)
        begin
            last_avg_reg    <= avg_new;
            out_value_reg   <= value_new;
            out_channel_reg <= s1_cmd_reg.channel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_channel = out_channel_reg;

    `ASSERT_CLK(a_fire_fills_out, clk, rst_n, s1_fire |=> out_valid_reg, "retired word lost")
    `ASSERT_CLK(a_stall_holds, clk, rst_n, (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_cmd_reg) && $stable(fwd_reg)), "read stage changed while stalled")
    `ASSERT_NEVER(a_no_bubble, clk, rst_n, s1_fire && qstat.valid && !pop, "queue not drained on retire")

endmodule

@@ hw/rtl/multichannel_exponential_filter_core.sv @@
// ---------------------------------------------------------------------------
// multichannel_exponential_filter_core
// per-channel first-order exponential average, low-pass or high-pass output
// ---------------------------------------------------------------------------
//
// channel   dir  handshake                   word
// --------  ---  --------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid/tready        tdata: sample, channel; tuser: init
// m_axis    out  m_axis_tvalid/tready        tdata: value, out_channel
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// one word per cycle sustained while m_axis_tready stays high; a word moves through
// the input register, queue, memory read and update into the result register
// the loop that sets the rate is average -> 32x17 multiply -> add -> memory
// write, closed by forwarding the last average to the read stage
// reset clears the control state only; a channel's average is undefined until
// an initialize word is seen on that channel
// an output stall fills the result register, then the read stage, then the
// four-entry queue and the input register, and only then drops s_axis_tready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_exponential_filter_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    // input words
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] sample, [21:16] channel, upper bits zero
    input  logic [emaf_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
    // [0] initialize
    input  logic [emaf_pkg::IN_USER_BITS-1:0]       s_axis_tuser,

    // result words
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [32:0] value, [38:33] out_channel, upper bits zero
    output logic [emaf_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,

    // register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [emaf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [emaf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // configuration registers
    logic                                   lowpass_mode_reg, lowpass_mode_next;
    logic [emaf_pkg::WEIGHT_BITS-1:0]       new_weight_reg, new_weight_next;

    emaf_pkg::emaf_cfg_t                    cfg;
    emaf_pkg::emaf_cmd_t                    push_cmd;
    emaf_pkg::emaf_cmd_t                    head_cmd;
    emaf_pkg::emaf_qstat_t                  qstat;
    logic                                   push;
    logic                                   pop;
    logic [emaf_pkg::VALUE_BITS-1:0]        out_value;
    logic [emaf_pkg::CH_BITS-1:0]           out_channel;
    logic                                   cfg_write;

    // the user must write only while idle, which the block does not enforce; the port never stalls
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        lowpass_mode_next = lowpass_mode_reg;
        new_weight_next   = new_weight_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                emaf_pkg::REG_LOWPASS_MODE: lowpass_mode_next = cfg_data[0];
                emaf_pkg::REG_NEW_WEIGHT:   new_weight_next   = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowpass_mode_reg <= 1'b1;
            new_weight_reg   <= emaf_pkg::ONE_Q >> 1;
        end
        else
        begin
            lowpass_mode_reg <= lowpass_mode_next;
            new_weight_reg   <= new_weight_next;
        end
    end

    // a weight above one saturates to one
    assign cfg.lowpass     = lowpass_mode_reg;
    assign cfg.weight      = (new_weight_reg > emaf_pkg::ONE_Q) ? emaf_pkg::ONE_Q
                                                                 : new_weight_reg;
    assign cfg.keep_weight = emaf_pkg::ONE_Q - cfg.weight;

    // front: accept and precompute the sample's share
    emaf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[emaf_pkg::SAMPLE_BITS-1:0]),
        .in_channel (s_axis_tdata[emaf_pkg::SAMPLE_BITS +: emaf_pkg::CH_BITS]),
        .in_init    (s_axis_tuser[0]),
        .cfg        (cfg),
        .qstat      (qstat),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    emaf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (qstat)
    );

    // back: read-modify-write of the channel average
    emaf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .cfg         (cfg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (out_value),
        .out_channel (out_channel)
    );

    assign m_axis_tdata = emaf_pkg::OUT_DATA_BITS'({out_channel, out_value});

endmodule

@@ sim/emaf_result_checker.sv @@
// ---------------------------------------------------------------------------
// emaf_result_checker
// predicts every filter result from the accepted input and register words
// and compares the result words against them in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emaf_result_checker
    import emaf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic [IN_USER_BITS-1:0]   s_axis_tuser,

    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0]  m_axis_tdata,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      run_done,
    output int                        outstanding,
    output int                        mismatches,
    output int                        checked
);

    localparam longint UNITY = longint'(1) << FRAC_BITS;
    localparam longint HALF  = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [CH_BITS-1:0]    channel;
    } filtered_word_t;

    filtered_word_t         filtered_q[$];
    longint                 channel_avg [CHANNELS];
    logic                   lowpass;
    logic [WEIGHT_BITS-1:0] weight;
    bit                     leftover_done;

    // one exponential step, rounding half up with a floor shift
    function automatic longint blend_average(input longint prior, input longint scaled,
                                             input logic [WEIGHT_BITS-1:0] w_raw);
        longint w;
        w = (longint'(w_raw) > UNITY) ? UNITY : longint'(w_raw);
        return (scaled * w + prior * (UNITY - w) + HALF) >>> FRAC_BITS;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_BITS-1:0]            ch;
        longint                        scaled;
        longint                        avg;
        longint                        res;
        filtered_word_t                want;
        filtered_word_t                got;
        int                            slot;

        if (!rst_n)
        begin
            filtered_q.delete();
            lowpass       = 1'b1;
            weight        = WEIGHT_BITS'(32768);
            leftover_done = 1'b0;
            mismatches    = 0;
            checked       = 0;
            outstanding  <= 0;
        end
        else
        begin
            // result side first: a word leaving now belongs to an older input
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value   = m_axis_tdata[VALUE_BITS-1:0];
                got.channel = m_axis_tdata[VALUE_BITS +: CH_BITS];
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value %h channel %0d",
                                              got.value, got.channel));
                else
                begin
                    want = filtered_q.pop_front();
                    checked++;
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value %h, predicted %h (channel %0d)",
                                                  got.value, want.value, want.channel));
                    if (got.channel !== want.channel)
                        report_mismatch($sformatf("out_channel %0d, predicted %0d",
                                                  got.channel, want.channel));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                smp    = s_axis_tdata[SAMPLE_BITS-1:0];
                ch     = s_axis_tdata[SAMPLE_BITS +: CH_BITS];
                slot   = int'(ch) % CHANNELS;
                scaled = longint'(smp) <<< FRAC_BITS;
                if (s_axis_tuser[0])
                    avg = scaled;
                else
                    avg = blend_average(channel_avg[slot], scaled, weight);
                channel_avg[slot] = avg;
                res = lowpass ? avg : scaled - avg;
                want.value   = res[VALUE_BITS-1:0];
                want.channel = ch;
                filtered_q.push_back(want);
            end

            // register writes only come while the pipeline is empty
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOWPASS_MODE)
                    lowpass = cfg_data[0];
                else if (cfg_index == REG_NEW_WEIGHT)
                    weight = cfg_data[WEIGHT_BITS-1:0];
            end

            if (run_done && !leftover_done)
            begin
                leftover_done = 1'b1;
                if (filtered_q.size() != 0)
                    report_mismatch($sformatf("%0d predicted results never arrived",
                                              filtered_q.size()));
            end

            outstanding <= filtered_q.size();
        end
    end

endmodule

@@ sim/multichannel_exponential_filter_core_test.sv @@
// ---------------------------------------------------------------------------
// multichannel_exponential_filter_core_test
// drives sample words and register writes into the filter core with random
// gaps and output stalls; a checker beside the core predicts every result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_exponential_filter_core_test;

    import emaf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;   // far above the slowest legal run
    localparam int LONG_HOLD     = 300;      // output stall that backs up the input
    localparam int TAIL_CYCLES   = 20;       // margin after draining, before run_done
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 100;
    localparam int HOLD_PHASE    = 3;
    localparam int PAUSE_PHASE   = 5;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // [15:0] sample, [21:16] channel, upper bits zero
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    // [0] initialize
    logic [IN_USER_BITS-1:0]   s_axis_tuser = '0;

    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [32:0] value, [38:33] out_channel, upper bits zero
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic                      run_done = 1'b0;
    int                        outstanding;
    int                        mismatches;
    int                        checked;

    int                        cycle_count = 0;
    int                        hold_requests = 0;   // bumped to ask the sink for a long hold
    int                        words_sent = 0;
    int                        settings_used = 0;
    int                        sender_quiet = 0;    // words left in a gap-free stretch
    bit                        steady_feed = 1'b0;  // sender never idles while set

    // channels that have seen an initialize word; others are never updated
    bit                        primed [CHANNELS];
    logic [SAMPLE_BITS-1:0]    last_sample [CHANNELS];
    logic [CH_BITS-1:0]        hot_channel [4];

    multichannel_exponential_filter_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    emaf_result_checker result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .run_done      (run_done),
        .outstanding   (outstanding),
        .mismatches    (mismatches),
        .checked       (checked)
    );

    // 125 MHz
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, outstanding);
            $display("multichannel_exponential_filter_core_test NOT OK");
            $finish;
        end
    end

    // idle length shared by both sides: mostly none or short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // full-range noise, rail values, or a small step from the channel's last sample
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] last);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return SAMPLE_BITS'($urandom);
        if (pick < 60)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return last + SAMPLE_BITS'($urandom_range(0, 512)) - SAMPLE_BITS'(256);
    endfunction

    // weights at and around zero and one, the saturating range and random ones
    function automatic logic [CFG_DATA_BITS-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_BITS'(1);
            2:       return CFG_DATA_BITS'(65535);
            3:       return CFG_DATA_BITS'(ONE_Q);
            4:       return CFG_DATA_BITS'(ONE_Q) + CFG_DATA_BITS'(1);
            5:       return '1;
            6:       return CFG_DATA_BITS'($urandom);
            default: return CFG_DATA_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    // one sample word; returns at the edge where it was taken
    task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic [CH_BITS-1:0] ch,
                             input logic init);
        int gap;
        if (sender_quiet > 0)
            sender_quiet--;
        else if ($urandom_range(0, 49) == 0)
            sender_quiet = $urandom_range(10, 60);
        gap = (steady_feed || sender_quiet > 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_BITS - SAMPLE_BITS - CH_BITS){1'b0}}, ch, smp};
        s_axis_tuser  <= init;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (init)
            primed[ch] = 1'b1;
        words_sent++;
    endtask

    // stop feeding and wait for every predicted result to come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // both registers back to back, valid held high across the two words
    task automatic write_settings(input logic [CFG_DATA_BITS-1:0] mode_word,
                                  input logic [CFG_DATA_BITS-1:0] weight);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOWPASS_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_NEW_WEIGHT;
        cfg_data  <= weight;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // random word: unprimed channels always start with an initialize word
    task automatic random_word();
        logic [CH_BITS-1:0] ch;
        logic               init;
        if ($urandom_range(0, 9) < 3)
            ch = hot_channel[$urandom_range(0, 3)];
        else
            ch = CH_BITS'($urandom);
        init = !primed[ch] || ($urandom_range(0, 24) == 0);
        last_sample[ch] = pick_sample(last_sample[ch]);
        send_word(last_sample[ch], ch, init);
    endtask

    // output side: ready bursts broken by stalls, plus long holds on request
    initial
    begin : result_sink
        int stall;
        int quiet_left;
        int holds_served;
        quiet_left   = 0;
        holds_served = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 29) == 0)
                quiet_left = $urandom_range(5, 20);
            stall = (quiet_left > 0) ? 0 : idle_length();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int                       phase;
        int                       k;
        int                       directed_words;
        logic [CFG_DATA_BITS-1:0] mode_word;

        for (k = 0; k < CHANNELS; k++)
        begin
            primed[k]      = 1'b0;
            last_sample[k] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: low-pass, weight one half; rails on the edge channels
        send_word(16'h7FFF, 6'd0,  1'b1);
        send_word(16'h8000, 6'd63, 1'b1);
        send_word(16'h0000, 6'd1,  1'b1);
        send_word(16'h8000, 6'd0,  1'b0);
        send_word(16'h7FFF, 6'd63, 1'b0);
        send_word(16'h8000, 6'd0,  1'b0);
        send_word(16'hFFFF, 6'd1,  1'b0);
        send_word(16'hFFFF, 6'd62, 1'b1);
        send_word(16'h0001, 6'd62, 1'b0);
        send_word(16'h7FFF, 6'd63, 1'b0);

        // high-pass with a weight above one, which saturates
        drain_results();
        write_settings(CFG_DATA_BITS'(0), '1);
        send_word(16'h7FFF, 6'd0,  1'b0);
        send_word(16'h8000, 6'd63, 1'b0);
        send_word(16'h3039, 6'd5,  1'b1);
        send_word(16'hCFC7, 6'd5,  1'b0);

        // low-pass through a mode word with junk above bit 0, zero weight
        drain_results();
        write_settings('1, '0);
        send_word(16'h8000, 6'd0,  1'b0);
        send_word(16'h7FFF, 6'd63, 1'b0);
        send_word(16'h5555, 6'd42, 1'b1);
        send_word(16'hAAAA, 6'd42, 1'b0);

        // high-pass through a junk mode word, weight exactly one
        drain_results();
        write_settings(CFG_DATA_BITS'(17'h1FFFE), CFG_DATA_BITS'(ONE_Q));
        send_word(16'h8000, 6'd63, 1'b0);
        send_word(16'h7FFF, 6'd0,  1'b0);
        send_word(16'h2AAA, 6'd21, 1'b1);
        directed_words = words_sent;

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            mode_word = CFG_DATA_BITS'($urandom);
            if ($urandom_range(0, 1) == 0)
                mode_word = '0;
            mode_word[0] = $urandom_range(0, 1);
            write_settings(mode_word, pick_weight());
            for (k = 0; k < 4; k++)
                hot_channel[k] = CH_BITS'($urandom);

            // output held off while the input keeps offering words
            if (phase == HOLD_PHASE)
            begin
                hold_requests <= hold_requests + 1;
                steady_feed = 1'b1;
                for (k = 0; k < 48; k++)
                    random_word();
                steady_feed = 1'b0;
            end

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // sender waits mid-phase for the pipeline to empty
                if (phase == PAUSE_PHASE && k == PHASE_WORDS / 2)
                    drain_results();
                random_word();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("sent %0d sample words (%0d directed) across %0d register settings",
                 words_sent, directed_words, settings_used + 1);
        $display("checked %0d results, %0d long output holds, %0d cycles",
                 checked, hold_requests, cycle_count);
        if (mismatches == 0)
            $display("multichannel_exponential_filter_core_test OK");
        else
            $display("multichannel_exponential_filter_core_test NOT OK");
        $finish;
    end

endmodule

@@ multichannel_exponential_filter_core.f @@
+incdir+hw/rtl
hw/rtl/emaf_pkg.sv
hw/rtl/emaf_queue.sv
hw/rtl/emaf_front.sv
hw/rtl/emaf_back.sv
hw/rtl/multichannel_exponential_filter_core.sv
sim/emaf_result_checker.sv
sim/multichannel_exponential_filter_core_test.sv
